### rtl/interleaved_space_to_depth_core_assert.svh
// Assertion macros for the space-to-depth core.
// Each macro expects clk and rst_n in scope.
`ifndef INTERLEAVED_SPACE_TO_DEPTH_CORE_ASSERT_SVH
`define INTERLEAVED_SPACE_TO_DEPTH_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define ISD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("isd assertion failed");

// Next-cycle implication.
`define ISD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("isd assertion failed");

`else

`define ISD_ASSERT_NOW(label, ante, cons)
`define ISD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### rtl/isd_pkg.sv
package isd_pkg;

  localparam int CFG_W  = 10;
  localparam int CHAN_W = 8;
  localparam int PIX_W  = 3 * CHAN_W;
  localparam int POS_W  = 8;

  localparam int MAX_WIDTH_DEF      = 512;
  localparam int MAX_HEIGHT_DEF     = 512;
  localparam int PIXEL_CHANNELS_DEF = 3;

  localparam logic [CFG_W-1:0] WIDTH_RST  = 10'd320;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 10'd240;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [1:0] QUAD_TL = 2'd0;
  localparam logic [1:0] QUAD_BL = 2'd1;
  localparam logic [1:0] QUAD_TR = 2'd2;
  localparam logic [1:0] QUAD_BR = 2'd3;

  typedef logic [PIX_W-1:0] pix_t;

  // Per-pixel output metadata handed from the front end to the output stage.
  typedef struct packed {
    logic [POS_W-1:0] orow;
    logic [POS_W-1:0] ocol;
    logic             right;  // odd column: TR/BR pair
    logic             flast;  // last output pixel of frame
  } isd_meta_t;

endpackage

### rtl/isd_line_buf.sv
module isd_line_buf #(
  parameter int DEPTH = isd_pkg::MAX_WIDTH_DEF,
  parameter int AW    = $clog2(isd_pkg::MAX_WIDTH_DEF)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  isd_pkg::pix_t        wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr,
  output isd_pkg::pix_t        rdata
);
  import isd_pkg::*;

  pix_t mem [DEPTH];
  pix_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/isd_out_stage.sv
module isd_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  isd_pkg::pix_t      above,
  input  isd_pkg::pix_t      cur,
  input  isd_pkg::isd_meta_t meta,
  output logic               ready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [39:0]        out_tdata,
  output logic [2:0]         out_tuser,
  output logic               out_tlast
);
  import isd_pkg::*;

  logic      valid_r, valid_nxt;
  logic      phase_r, phase_nxt;
  pix_t      above_r, cur_r;
  isd_meta_t meta_r;
  pix_t      sel;
  logic      beat;

  assign beat  = valid_r & out_tready;
  assign ready = ~valid_r | (out_tready & phase_r);

  always_comb begin
    valid_nxt = valid_r;
    phase_nxt = phase_r;
    if (load) begin
      valid_nxt = 1'b1;
      phase_nxt = 1'b0;
    end else if (beat) begin
      if (phase_r) begin
        valid_nxt = 1'b0;
      end else begin
        phase_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      above_r <= above;
      cur_r   <= cur;
      meta_r  <= meta;
    end
  end

  assign sel = phase_r ? cur_r : above_r;

  always_comb begin
    out_tdata  = {meta_r.ocol, meta_r.orow, sel[7:0], sel[15:8], sel[23:16]};
    case ({meta_r.right, phase_r})
      2'b00:   out_tuser[1:0] = QUAD_TL;
      2'b01:   out_tuser[1:0] = QUAD_BL;
      2'b10:   out_tuser[1:0] = QUAD_TR;
      2'b11:   out_tuser[1:0] = QUAD_BR;
      default: out_tuser[1:0] = QUAD_TL;
    endcase
    out_tuser[2] = meta_r.right & phase_r;
    out_tlast    = meta_r.right & phase_r & meta_r.flast;
  end

  assign out_tvalid = valid_r;

endmodule

### rtl/interleaved_space_to_depth_core.sv
// The first beat of a pixel's pair is offered after stage 1 hands the pixel to the output stage.
// Even-row pixels only fill the line store; odd-row pixels in the trimmed area each give
//   two quadrant beats on the single output port, and a busy output stage holds off input.
// Reset (sync, rst_n low): counters to zero, width/height to 320/240, output
//   empty. The line store is not cleared and needs no clearing pass.
module interleaved_space_to_depth_core #(
  parameter int MAX_WIDTH      = isd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT     = isd_pkg::MAX_HEIGHT_DEF,
  parameter int PIXEL_CHANNELS = isd_pkg::PIXEL_CHANNELS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // config write port
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [isd_pkg::CFG_W-1:0] cfg_data,
  // input pixels; tdata: chan_a, chan_b, chan_c
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [PIXEL_CHANNELS*8-1:0] in_tdata,
  // results; tdata: out_first, out_second, out_third, out_row, out_col
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [39:0]              out_tdata,
  // tuser: quadrant[1:0], pixel_last; tlast: frame_last
  output logic [2:0]               out_tuser,
  output logic                     out_tlast
);
  import isd_pkg::*;

  `include "interleaved_space_to_depth_core_assert.svh"

  localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW0 = $clog2(MAX_WIDTH + 1);
  localparam int HW0 = $clog2(MAX_HEIGHT + 1);
  localparam int WW  = (WW0 > CFG_W) ? WW0 : CFG_W;
  localparam int HW  = (HW0 > CFG_W) ? HW0 : CFG_W;

  // config registers
  logic [CFG_W-1:0] width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  width_r  <= cfg_data;
        REG_FRAME_HEIGHT: height_r <= cfg_data;
        default:          ;
      endcase
    end
  end

  // effective dimensions, saturated into [2, MAX]
  logic [WW-1:0] w_eff, w_ext;
  logic [HW-1:0] h_eff, h_ext;

  always_comb begin
    w_ext = WW'(width_r);
    h_ext = HW'(height_r);
    if (w_ext < WW'(2))              w_eff = WW'(2);
    else if (w_ext > WW'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else                             w_eff = w_ext;
    if (h_ext < HW'(2))               h_eff = HW'(2);
    else if (h_ext > HW'(MAX_HEIGHT)) h_eff = HW'(MAX_HEIGHT);
    else                              h_eff = h_ext;
  end

  // raster position counters
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [WW-1:0] col_inc;
  logic [HW-1:0] row_inc;
  logic          in_acc;
  logic          emit;

  assign in_acc  = in_tvalid & in_tready;
  assign col_inc = WW'(col_r) + WW'(1);
  assign row_inc = HW'(row_r) + HW'(1);

  // odd row inside the even-trimmed frame area produces a quadrant pair
  assign emit = row_r[0]
              & (HW'(row_r) < (h_eff & ~HW'(1)))
              & (WW'(col_r) < (w_eff & ~WW'(1)));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (col_inc >= w_eff) begin
        col_nxt = '0;
        row_nxt = (row_inc >= h_eff) ? '0 : RW'(row_inc);
      end else begin
        col_nxt = CW'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // line store: even rows write, odd rows read; never both in one cycle
  pix_t cur_pix, above_pix;

  assign cur_pix = PIX_W'(in_tdata);

  isd_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_buf (
    .clk   (clk),
    .we    (in_acc & ~row_r[0]),
    .waddr (col_r),
    .wdata (cur_pix),
    .re    (in_acc & emit),
    .raddr (col_r),
    .rdata (above_pix)
  );

  // stage 1: holds the current pixel while the store read completes.
  // The store's read register holds as long as this stage does, since a
  // new read only happens with a new accept.
  logic      s1_valid_r, s1_valid_nxt;
  pix_t      s1_pix_r;
  isd_meta_t s1_meta_r, meta_now;
  logic      pb_ready;
  logic      pb_load;

  assign pb_load   = s1_valid_r & pb_ready;
  assign in_tready = ~s1_valid_r | pb_ready;

  always_comb begin
    meta_now.orow  = POS_W'(row_r >> 1);
    meta_now.ocol  = POS_W'(col_r >> 1);
    meta_now.right = col_r[0];
    // full-width compare: position not taken modulo 256 here
    meta_now.flast = (HW'(row_r >> 1) == ((h_eff >> 1) - HW'(1)))
                   & (WW'(col_r >> 1) == ((w_eff >> 1) - WW'(1)));
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc & emit)  s1_valid_nxt = 1'b1;
    else if (pb_load)   s1_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc & emit) begin
      s1_pix_r  <= cur_pix;
      s1_meta_r <= meta_now;
    end
  end

  // stage 2: quadrant pair, two beats out
  isd_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (pb_load),
    .above      (above_pix),
    .cur        (s1_pix_r),
    .meta       (s1_meta_r),
    .ready      (pb_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // a full stage 1 that cannot drain must block input
  `ISD_ASSERT_NOW(a_s1_block, s1_valid_r && !pb_ready, !in_tready)
  // an emitting beat always lands in stage 1
  `ISD_ASSERT_NEXT(a_s1_fill, in_acc && emit, s1_valid_r)
  // frame end only on a bottom-right beat
  `ISD_ASSERT_NOW(a_flast_br, out_tvalid && out_tlast,
                  out_tuser[2] && (out_tuser[1:0] == QUAD_BR))
  // stage 1 handoff needs a free output pair
  `ISD_ASSERT_NEXT(a_pb_load, pb_load, out_tvalid)

endmodule

### test/tb_interleaved_space_to_depth_core.sv
module tb_interleaved_space_to_depth_core;
  timeunit 1ns;
  timeprecision 1ps;

  import isd_pkg::*;

  // Timeout budget in clock cycles.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  // Settle margin after the last expected beat, before cfg writes.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_PIXELS = 360;

  // One expected result beat: data bytes, quadrant, position and last flags.
  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
    logic [7:0] third;
    logic [1:0] quad;
    logic [7:0] row;
    logic [7:0] col;
    logic       plast;
    logic       flast;
  } quad_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             cfg_we = 1'b0;
  logic             cfg_index = REG_FRAME_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;

  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [23:0] in_tdata = '0;   // chan_a [7:0], chan_b [15:8], chan_c [23:16]

  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // out_first, out_second, out_third, out_row, out_col
  logic [2:0]  out_tuser;       // quadrant [1:0], pixel_last [2]
  logic        out_tlast;       // frame_last

  interleaved_space_to_depth_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Slice predictor: mirrors the block's counters, registers and line store.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] width_reg  = WIDTH_RST;
  logic [CFG_W-1:0] height_reg = HEIGHT_RST;
  int unsigned      col_cnt = 0;
  int unsigned      row_cnt = 0;
  pix_t             line_mem [MAX_WIDTH_DEF];

  quad_beat_t quad_q[$];   // expected result beats, oldest first

  int unsigned fail_cnt   = 0;
  int unsigned px_cnt     = 0;
  int unsigned beat_cnt   = 0;
  int unsigned frame_ends = 0;
  int unsigned cycle_cnt  = 0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // Register value as the block uses it: saturated into [2, hi].
  function automatic int unsigned eff_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  // Quadrant bytes leave in reversed channel order (BGR out of RGB).
  function automatic void push_quad(input pix_t src, input logic [1:0] q,
                                    input int unsigned r, input int unsigned c,
                                    input logic pl, input logic fl);
    quad_beat_t b;
    b.first  = src[23:16];
    b.second = src[15:8];
    b.third  = src[7:0];
    b.quad   = q;
    b.row    = r[7:0];
    b.col    = c[7:0];
    b.plast  = pl;
    b.flast  = fl;
    quad_q.push_back(b);
  endfunction

  function automatic void slice_pixel(input pix_t px);
    int unsigned w;
    int unsigned h;
    int unsigned orow;
    int unsigned ocol;
    pix_t        above;
    w = eff_dim(width_reg, MAX_WIDTH_DEF);
    h = eff_dim(height_reg, MAX_HEIGHT_DEF);
    if (row_cnt % 2 == 0) begin
      if (col_cnt < MAX_WIDTH_DEF) line_mem[col_cnt] = px;
    end else if (row_cnt < (h & ~1) && col_cnt < (w & ~1)) begin
      // odd row inside the even-sized crop: stored pixel above, then this one
      above = line_mem[col_cnt];
      orow  = row_cnt >> 1;
      ocol  = col_cnt >> 1;
      if (col_cnt % 2 == 0) begin
        push_quad(above, QUAD_TL, orow, ocol, 1'b0, 1'b0);
        push_quad(px, QUAD_BL, orow, ocol, 1'b0, 1'b0);
      end else begin
        push_quad(above, QUAD_TR, orow, ocol, 1'b0, 1'b0);
        push_quad(px, QUAD_BR, orow, ocol, 1'b1,
                  (orow == h / 2 - 1) && (ocol == w / 2 - 1));
      end
    end
    // counters wrap on reaching or passing the (possibly just shrunk) size
    col_cnt++;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
      if (row_cnt >= h) row_cnt = 0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Random backpressure; decided each falling edge.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // One pixel beat; returns at the rising edge where it was accepted.
  // tvalid is only lowered for a gap, never dropped and raised in one step.
  task automatic send_pixel(input pix_t px);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    do @(posedge clk); while (!in_tready);
    slice_pixel(px);
    px_cnt++;
  endtask

  // Drain: input idle, then wait until every expected beat has been seen
  // and the settle margin has passed.
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (quad_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FRAME_WIDTH) width_reg = val;
    else height_reg = val;
  endtask

  task automatic set_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
  endtask

  // Random pixels until the counters are back at the frame origin.
  task automatic finish_frame();
    while (row_cnt != 0 || col_cnt != 0) send_pixel(PIX_W'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  quad_beat_t want;

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (quad_q.size() == 0) begin
        $error("result beat with nothing expected: tdata 0x%0h tuser 0x%0h",
               out_tdata, out_tuser);
        fail_cnt++;
      end else begin
        want = quad_q.pop_front();
        check_field("out_first",  want.first,  out_tdata[7:0]);
        check_field("out_second", want.second, out_tdata[15:8]);
        check_field("out_third",  want.third,  out_tdata[23:16]);
        check_field("out_row",    want.row,    out_tdata[31:24]);
        check_field("out_col",    want.col,    out_tdata[39:32]);
        check_field("quadrant",   want.quad,   out_tuser[1:0]);
        check_field("pixel_last", want.plast,  out_tuser[2]);
        check_field("frame_last", want.flast,  out_tlast);
        beat_cnt++;
        if (want.flast) frame_ends++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected",
               cycle_cnt, quad_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset geometry is 320 wide: two full rows give 640 quadrant beats with
  // the right columns only if the width register really came up at 320.
  // Row 0 also fills store entries 0..319, so later mid-frame writes on
  // small frames only read entries that hold data.
  task automatic test_reset_geometry();
    set_idling(22, 87);
    repeat (2 * 320) send_pixel(PIX_W'($urandom));
  endtask

  // Write while the counters sit mid-frame (row 2). The second write shrinks
  // the width below the current column: that pixel is consumed without
  // result and the column wraps. Reads stay on entries written above.
  task automatic test_midframe_write();
    set_idling(22, 87);
    settle();
    set_geometry(10'd6, 10'd6);
    repeat (3) send_pixel(PIX_W'($urandom));
    settle();
    write_reg(REG_FRAME_WIDTH, 10'd2);
    finish_frame();
    settle();
  endtask

  // Smallest frame with all-zero / all-one bytes, trailing odd column and
  // row dropped, and register values below the minimum.
  task automatic test_corners();
    set_idling(22, 87);
    set_geometry(10'd2, 10'd2);
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h55AA55);
    send_pixel(24'hAA55AA);
    settle();
    // 3x3: column 2 and row 2 produce nothing
    set_geometry(10'd3, 10'd3);
    send_pixel(24'h030201);
    send_pixel(24'h060504);
    send_pixel(24'h090807);
    send_pixel(24'h0C0B0A);
    send_pixel(24'h0F0E0D);
    send_pixel(24'h121110);
    send_pixel(24'h151413);
    send_pixel(24'h181716);
    send_pixel(24'h1B1A19);
    settle();
    // 0 and 1 saturate up to 2
    set_geometry(10'd0, 10'd1);
    send_pixel(24'h80FF01);
    send_pixel(24'h7F00FE);
    send_pixel(24'hC33C00);
    send_pixel(24'h00C33C);
    settle();
  endtask

  // Random small frames, random content, occasional mid-frame register write.
  task automatic test_random_frames();
    int unsigned start_px;
    int unsigned split;
    int unsigned n;
    int unsigned done;
    start_px = px_cnt;
    while (px_cnt - start_px < RANDOM_PIXELS) begin
      done = px_cnt - start_px;
      if (done < RANDOM_PIXELS / 3) set_idling(22, 87);
      else if (done < 2 * RANDOM_PIXELS / 3) set_idling(87, 22);
      else set_idling(0, 0);
      if ($urandom_range(0, 3) != 0)
        write_reg(REG_FRAME_WIDTH, CFG_W'(($urandom_range(0, 9) == 0) ?
                  $urandom_range(0, 1) : $urandom_range(2, 16)));
      if ($urandom_range(0, 3) != 0)
        write_reg(REG_FRAME_HEIGHT, CFG_W'(($urandom_range(0, 9) == 0) ?
                  $urandom_range(0, 1) : $urandom_range(2, 16)));
      split = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 40) : 0;
      n = 0;
      do begin
        send_pixel(PIX_W'($urandom));
        n++;
        if (n == split) begin
          settle();
          write_reg($urandom_range(0, 1) ? REG_FRAME_HEIGHT : REG_FRAME_WIDTH,
                    CFG_W'($urandom_range(0, 16)));
        end
      end while (row_cnt != 0 || col_cnt != 0);
      settle();
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    test_reset_geometry();
    test_midframe_write();
    test_corners();
    test_random_frames();

    settle();
    if (quad_q.size() != 0) begin
      $error("%0d expected beats never arrived", quad_q.size());
      fail_cnt++;
    end

    $display("sent %0d pixels, checked %0d quadrant beats, %0d frame ends seen",
             px_cnt, beat_cnt, frame_ends);
    $display("reset 320-wide rows, 2x2 to 16x16 frames, saturated and mid-frame writes");
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
